/* hdl/cipu_pkg.sv */
package cipu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned AccW  = ProdW + 2;

  localparam logic signed [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

  typedef struct packed {
    logic signed [DataW-1:0] z_real;
    logic signed [DataW-1:0] z_imag;
    logic signed [ExpW-1:0]  exponent;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] w_real;
    logic signed [DataW-1:0] w_imag;
    logic                    overflow;
  } out_word_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic                    ovf;
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
  } cmul_status_t;

endpackage

/* hdl/cipu_cell.sv */
module cipu_cell
  import cipu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic shift_i,
  input  logic load_bit_i,
  input  logic next_bit_i,
  input  logic next_any_i,
  output logic bit_o,
  output logic any_o
);

  logic bit_q, bit_d;

  always_comb begin
    bit_d = bit_q;
    if (load_i) begin
      bit_d = load_bit_i;
    end else if (shift_i) begin
      bit_d = next_bit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;
  assign any_o = bit_q | next_any_i;

endmodule

/* hdl/cipu_cmul.sv */
module cipu_cmul
  import cipu_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DataW-1:0] a_re_i,
  input  logic signed [DataW-1:0] a_im_i,
  input  logic signed [DataW-1:0] b_re_i,
  input  logic signed [DataW-1:0] b_im_i,
  output cmul_status_t            status_o
);

  localparam logic [2:0] LastCnt = 3'd5;

  logic                    busy_q;
  logic [2:0]              cnt_q;
  logic signed [DataW-1:0] op_a, op_b;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_re_q, acc_im_q;
  logic signed [AccW-1:0]  sh_re, sh_im;
  logic                    ovf_re, ovf_im;

  always_comb begin
    unique case (cnt_q)
      3'd0: begin
        op_a = a_re_i;
        op_b = b_re_i;
      end
      3'd1: begin
        op_a = a_im_i;
        op_b = b_im_i;
      end
      3'd2: begin
        op_a = a_re_i;
        op_b = b_im_i;
      end
      default: begin
        op_a = a_im_i;
        op_b = b_re_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 3'd0;
    end else if (busy_q) begin
      if (cnt_q == LastCnt) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      prod_q <= op_a * op_b;
      unique case (cnt_q)
        3'd1:    acc_re_q <= AccW'(prod_q);
        3'd2:    acc_re_q <= acc_re_q - AccW'(prod_q);
        3'd3:    acc_im_q <= AccW'(prod_q);
        3'd4:    acc_im_q <= acc_im_q + AccW'(prod_q);
        default: ;
      endcase
    end
  end

  assign sh_re  = acc_re_q >>> FRAC_BITS;
  assign sh_im  = acc_im_q >>> FRAC_BITS;
  assign ovf_re = !((&sh_re[AccW-1:DataW-1]) || !(|sh_re[AccW-1:DataW-1]));
  assign ovf_im = !((&sh_im[AccW-1:DataW-1]) || !(|sh_im[AccW-1:DataW-1]));

  always_comb begin
    status_o.busy = busy_q;
    status_o.done = busy_q && (cnt_q == LastCnt);
    status_o.ovf  = ovf_re | ovf_im;
    status_o.re   = ovf_re ? (sh_re[AccW-1] ? SatMin : SatMax) : sh_re[DataW-1:0];
    status_o.im   = ovf_im ? (sh_im[AccW-1] ? SatMin : SatMax) : sh_im[DataW-1:0];
  end

endmodule

/* hdl/complex_integer_power_unit.sv */
// Complex integer power unit: w = z ** exponent in signed fixed point.
// The input channel (in_valid_i, in_ready_o, in_word_i) takes one word holding
// the base z and a signed exponent; the output channel (out_valid_o,
// out_ready_i, out_word_o) returns one word with the power and a sticky
// overflow flag for each input word, in order.
// The exponent is held in a row of bit cells that shifts toward the least
// significant bit after each squaring. One complex multiplier with a single
// 32 by 32 bit multiplier serves all products, one complex product at a time.
// An exponent with n significant bits and k set bits needs k products into
// the result and n - 1 squarings; an exponent of zero or below needs none.
// One word is in work at a time; in_ready_o is high while the unit is idle.
// A finished word sits in the output register, and a new input word is
// accepted while it waits; a second finished word waits until the receiver
// takes the first. A stalled receiver therefore stalls the input after one word.
// Reset clears all control state and drops any word in flight.
module complex_integer_power_unit
  import cipu_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 24,
  parameter int unsigned EXP_BITS  = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  typedef enum logic [2:0] {
    StIdle,
    StStep,
    StMul,
    StSqr,
    StDone
  } state_e;

  localparam logic signed [DataW-1:0] One = DataW'(1) << FRAC_BITS;

  state_e                  state_q;
  logic signed [DataW-1:0] rr_q, ri_q, vr_q, vi_q;
  logic                    ovf_q;
  logic                    out_valid_q;
  out_word_t               out_q;

  logic                    in_acc;
  logic [EXP_BITS-1:0]     exp_eff;
  logic                    exp_pos;
  logic [EXP_BITS:0]       bits;
  logic [EXP_BITS:0]       anys;
  logic                    shift;
  logic                    start;
  logic                    out_free;
  logic signed [DataW-1:0] a_re, a_im;
  cmul_status_t            cm;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign exp_eff    = EXP_BITS'($unsigned(in_word_i.exponent));
  assign exp_pos    = !exp_eff[EXP_BITS-1] && (|exp_eff);
  assign shift      = (state_q == StSqr) && cm.done;
  assign out_free   = !out_valid_q || out_ready_i;

  assign bits[EXP_BITS] = 1'b0;
  assign anys[EXP_BITS] = 1'b0;

  for (genvar k = 0; k < EXP_BITS; k++) begin : g_cell
    cipu_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (in_acc),
      .shift_i    (shift),
      .load_bit_i (exp_pos & exp_eff[k]),
      .next_bit_i (bits[k+1]),
      .next_any_i (anys[k+1]),
      .bit_o      (bits[k]),
      .any_o      (anys[k])
    );
  end

  always_comb begin
    start = 1'b0;
    unique case (state_q)
      StStep:  start = anys[0];
      StMul:   start = cm.done && anys[1];
      default: start = 1'b0;
    endcase
  end

  assign a_re = (state_q == StSqr) ? vr_q : rr_q;
  assign a_im = (state_q == StSqr) ? vi_q : ri_q;

  cipu_cmul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .a_re_i   (a_re),
    .a_im_i   (a_im),
    .b_re_i   (vr_q),
    .b_im_i   (vi_q),
    .status_o (cm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == StDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            state_q <= StStep;
          end
        end
        StStep: begin
          if (!anys[0]) begin
            state_q <= StDone;
          end else if (bits[0]) begin
            state_q <= StMul;
          end else begin
            state_q <= StSqr;
          end
        end
        StMul: begin
          if (cm.done) begin
            state_q <= anys[1] ? StSqr : StDone;
          end
        end
        StSqr: begin
          if (cm.done) begin
            state_q <= StStep;
          end
        end
        StDone: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rr_q  <= One;
      ri_q  <= '0;
      vr_q  <= in_word_i.z_real;
      vi_q  <= in_word_i.z_imag;
      ovf_q <= 1'b0;
    end
    if ((state_q == StMul) && cm.done) begin
      rr_q  <= cm.re;
      ri_q  <= cm.im;
      ovf_q <= ovf_q | cm.ovf;
    end
    if (shift) begin
      vr_q  <= cm.re;
      vi_q  <= cm.im;
      ovf_q <= ovf_q | cm.ovf;
    end
    if ((state_q == StDone) && out_free) begin
      out_q.w_real   <= rr_q;
      out_q.w_imag   <= ri_q;
      out_q.overflow <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  a_idle_mul_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !cm.busy)
    else $error("multiplier busy while unit is idle");

  a_accept_to_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StStep))
    else $error("accepted word did not start stepping");

  a_square_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift |-> anys[1])
    else $error("square issued with no higher exponent bit left");

  a_nonpos_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !exp_pos) |=> !anys[0])
    else $error("exponent of zero or below loaded set bits");
`endif

endmodule

/* dv/tb.sv */
module tb;
  import cipu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits = 24;
  localparam int CycleLimit = 1000000;
  localparam int RandomWords = 1750;
  localparam logic signed [DataW-1:0] UnitQ = 32'sh0100_0000;

  typedef struct packed {
    logic                    sat;
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
  } cplx_t;

  typedef struct {
    logic signed [DataW-1:0] zr;
    logic signed [DataW-1:0] zi;
    logic signed [ExpW-1:0]  e;
    bit                      known;
    logic signed [DataW-1:0] wr;
    logic signed [DataW-1:0] wi;
    logic                    ovf;
  } vector_t;

  logic      clk = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  out_word_t pending_powers[$];
  int        n_faults = 0;
  int        n_shown = 0;
  int        n_cycles = 0;

  // Rows with known set carry a result that can be read off directly; the rest go
  // through the predictor.
  vector_t dir_vectors [23] = '{
    '{32'sh0123_4567, -32'sh0765_4321, 8'sd0, 1'b1, UnitQ, 32'sd0, 1'b0},
    '{SatMax, SatMin, -8'sd128, 1'b1, UnitQ, 32'sd0, 1'b0},
    '{SatMin, SatMax, -8'sd1, 1'b1, UnitQ, 32'sd0, 1'b0},
    '{SatMax, SatMin, 8'sd1, 1'b1, SatMax, SatMin, 1'b0},
    '{32'sd0, 32'sd0, 8'sd127, 1'b1, 32'sd0, 32'sd0, 1'b0},
    '{UnitQ, 32'sd0, 8'sd127, 1'b1, UnitQ, 32'sd0, 1'b0},
    '{32'sd0, UnitQ, 8'sd2, 1'b1, -UnitQ, 32'sd0, 1'b0},
    '{32'sd0, UnitQ, 8'sd3, 1'b1, 32'sd0, -UnitQ, 1'b0},
    '{32'sd0, UnitQ, 8'sd4, 1'b1, UnitQ, 32'sd0, 1'b0},
    '{32'sh0200_0000, 32'sd0, 8'sd7, 1'b1, SatMax, 32'sd0, 1'b1},
    '{32'sh1000_0000, 32'sd0, 8'sd1, 1'b1, 32'sh1000_0000, 32'sd0, 1'b0},
    '{32'sh1000_0000, 32'sd0, 8'sd2, 1'b1, SatMax, 32'sd0, 1'b1},
    '{-32'sh1000_0000, 32'sd0, 8'sd3, 1'b1, SatMin, 32'sd0, 1'b1},
    '{SatMin, SatMin, 8'sd2, 1'b1, 32'sd0, SatMax, 1'b1},
    '{SatMin, SatMax, 8'sd2, 1'b1, 32'sd255, SatMin, 1'b1},
    '{-32'sd1, 32'sd1, 8'sd2, 1'b1, 32'sd0, -32'sd1, 1'b0},
    '{SatMax, SatMax, 8'sd127, 1'b0, 32'sd0, 32'sd0, 1'b0},
    '{SatMin, 32'sd0, 8'sd127, 1'b0, 32'sd0, 32'sd0, 1'b0},
    '{32'sd0, SatMax, 8'sd64, 1'b0, 32'sd0, 32'sd0, 1'b0},
    '{32'sh0100_8000, -32'sh0000_4000, 8'sd85, 1'b0, 32'sd0, 32'sd0, 1'b0},
    '{-32'sh00F0_0000, 32'sh0030_0000, 8'sd42, 1'b0, 32'sd0, 32'sd0, 1'b0},
    '{32'sh00B5_04F3, 32'sh00B5_04F3, 8'sd8, 1'b0, 32'sd0, 32'sd0, 1'b0},
    '{-32'sd1, -32'sd1, 8'sd127, 1'b0, 32'sd0, 32'sd0, 1'b0}
  };

  complex_integer_power_unit #(
    .FRAC_BITS(FracBits),
    .EXP_BITS (ExpW)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  always #6 clk = ~clk;

  // Returns the saturation flag above the floored, clamped value of a*b -/+ c*d.
  function automatic logic [DataW:0] fx_dot(logic signed [DataW-1:0] a, logic signed [DataW-1:0] b,
                                           logic signed [DataW-1:0] c, logic signed [DataW-1:0] d,
                                           bit sub);
    logic signed [AccW-1:0] xa, xb, xc, xd, acc, q, hi, lo;
    xa = a;
    xb = b;
    xc = c;
    xd = d;
    hi = SatMax;
    lo = SatMin;
    acc = sub ? xa * xb - xc * xd : xa * xb + xc * xd;
    q = acc >>> FracBits;
    if (q > hi) return {1'b1, SatMax};
    if (q < lo) return {1'b1, SatMin};
    return {1'b0, q[DataW-1:0]};
  endfunction

  function automatic cplx_t cplx_mul(cplx_t a, cplx_t b);
    logic [DataW:0] re, im;
    cplx_t r;
    re = fx_dot(a.re, b.re, a.im, b.im, 1'b1);
    im = fx_dot(a.re, b.im, a.im, b.re, 1'b0);
    r.re = re[DataW-1:0];
    r.im = im[DataW-1:0];
    r.sat = a.sat | b.sat | re[DataW] | im[DataW];
    return r;
  endfunction

  function automatic out_word_t complex_power(in_word_t w);
    cplx_t acc, pw;
    logic [ExpW-1:0] p;
    out_word_t r;
    acc = '0;
    acc.re = UnitQ;
    pw.sat = 1'b0;
    pw.re = w.z_real;
    pw.im = w.z_imag;
    if (w.exponent > 0) begin
      p = w.exponent;
      while (p != 0) begin
        if (p[0]) acc = cplx_mul(acc, pw);
        p = p >> 1;
        if (p != 0) pw = cplx_mul(pw, pw);
      end
    end
    r.w_real = acc.re;
    r.w_imag = acc.im;
    r.overflow = acc.sat;
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] rand_part();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      2: return (($urandom_range(0, 1) == 1) ? UnitQ : -UnitQ)
                + int'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      3: return int'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      default: return int'($urandom_range(0, 32'h0000_1000)) - 32'sh0000_0800;
    endcase
  endfunction

  function automatic logic signed [ExpW-1:0] rand_exponent();
    case ($urandom_range(0, 3))
      0: return ExpW'($urandom_range(0, 255));
      1: return ExpW'($urandom_range(1, 15));
      default: return ExpW'($urandom_range(1, 127));
    endcase
  endfunction

  task automatic offer(in_word_t w, out_word_t want, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    pending_powers.push_back(want);
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (pending_powers.size() == 0) begin
      n_faults++;
      if (n_shown < 10) begin
        n_shown++;
        $display("Unexpected word: %0d %0d %0b", got.w_real, got.w_imag, got.overflow);
      end
      return;
    end
    want = pending_powers.pop_front();
    if (got.w_real !== want.w_real || got.w_imag !== want.w_imag ||
        got.overflow !== want.overflow) begin
      n_faults++;
      if (n_shown < 10) begin
        n_shown++;
        $display("Mismatch: expected %0d %0d %0b, got %0d %0d %0b", want.w_real, want.w_imag,
                 want.overflow, got.w_real, got.w_imag, got.overflow);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_ni && out_valid && out_ready) check_word(out_word);
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiver takes one long break so that a finished word backs up into the input.
  initial begin : drain
    int taken;
    int stall;
    taken = 0;
    wait (rst_ni);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, 5);
      if ((taken / 100) % 4 == 1) stall = 0;
      if (taken == 250) stall = 400;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : feed
    in_word_t w;
    out_word_t want;
    int gap;
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    foreach (dir_vectors[i]) begin
      w.z_real = dir_vectors[i].zr;
      w.z_imag = dir_vectors[i].zi;
      w.exponent = dir_vectors[i].e;
      if (dir_vectors[i].known) begin
        want.w_real = dir_vectors[i].wr;
        want.w_imag = dir_vectors[i].wi;
        want.overflow = dir_vectors[i].ovf;
      end else begin
        want = complex_power(w);
      end
      offer(w, want, $urandom_range(0, 5));
    end
    for (int i = 0; i < RandomWords; i++) begin
      w.z_real = rand_part();
      w.z_imag = rand_part();
      w.exponent = rand_exponent();
      gap = $urandom_range(0, 5);
      if ((i / 100) % 4 == 3) gap = 0;
      offer(w, complex_power(w), gap);
    end
    in_valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_faults == 0 && pending_powers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
